// File: src/otp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otp_pkg
// Shared types and constants of the one-shot timer pool.
// ----------------------------------------------------------------------------
package otp_pkg;

  localparam int unsigned OPCODE_W    = 1;
  localparam int unsigned NOW_W       = 48;
  localparam int unsigned DELAY_W     = 32;
  localparam int unsigned HANDLE_W    = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE = 1'b0,
    OP_CHECK  = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED = 2'd0,
    ST_EXPIRED = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREATE,
    S_CHECK,
    S_FINAL
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // load item, restart slot scan
    logic next_slot;    // create: step to next slot
    logic create_take;  // create: claim current slot and report it
    logic emit_full;    // create: report pool full
    logic scan;         // check: run expiry scan
    logic emit_final;   // check: report last expiry or none
  } otp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;     // output register can take a beat this cycle
    logic slot_free;    // current slot is not active
    logic idx_end;      // current slot is the highest one
    logic scan_done;    // expiry scan finished, pipeline empty
  } otp_sts_t;

endpackage

// File: src/otp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module otp_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/otp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otp_ctrl
// Sequencer: accepts one item, steps the create search or runs the check
// scan, then issues the closing result.
// ----------------------------------------------------------------------------
module otp_ctrl
  import otp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_opcode,
  output logic     in_ready,
  input  otp_sts_t sts,
  output otp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (opcode_t'(in_opcode) == OP_CHECK) ? S_CHECK : S_CREATE;
        end
      end
      S_CREATE: begin
        if (sts.out_free) begin
          priority if (sts.slot_free) begin
            cmd.create_take = 1'b1;
            state_nxt       = S_IDLE;
          end else if (sts.idx_end) begin
            cmd.emit_full = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            cmd.next_slot = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.scan_done) begin
          state_nxt = S_FINAL;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/otp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otp_datapath
// Item registers, active bits, deadline/handle RAM, scan pipeline,
// held expiry and output register.
// ----------------------------------------------------------------------------
module otp_datapath
  import otp_pkg::*;
#(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned TICK_BITS   = 48,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [NOW_W-1:0]    in_now_tick,
  input  logic [DELAY_W-1:0]  in_delay_ticks,
  input  logic [HANDLE_W-1:0] in_handle,
  input  otp_cmd_t            cmd,
  output otp_sts_t            sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [HANDLE_W-1:0] out_expired_handle,
  output logic                out_last
);

  localparam int unsigned IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SUM_W  = ((TICK_BITS > DELAY_W) ? TICK_BITS : DELAY_W) + 1;
  localparam int unsigned DATA_W = TICK_BITS + HANDLE_BITS;

  // item
  logic [TICK_BITS-1:0]   now_r;
  logic [TICK_BITS-1:0]   dl_r;
  logic [HANDLE_BITS-1:0] hnd_r;

  // scan
  logic [IDX_W-1:0] idx_r;
  logic             issue_done_r;
  logic             rd_v_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [CNT_W-1:0] n_r;
  logic [SLOTS-1:0] active_r;

  // held expiry, reported once the next one shows up or the scan ends
  logic                   pend_v_r;
  logic [SLOT_W-1:0]      pend_slot_r;
  logic [HANDLE_BITS-1:0] pend_hnd_r;

  // output register
  logic                out_valid_r;
  status_t             out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [HANDLE_W-1:0] out_hnd_r;
  logic                out_last_r;

  logic [TICK_BITS-1:0]   now_w;
  logic [SUM_W-1:0]       sum_w;
  logic [TICK_BITS-1:0]   dl_w;
  logic [DATA_W-1:0]      rdata;
  logic [TICK_BITS-1:0]   rd_deadline;
  logic [HANDLE_BITS-1:0] rd_hnd;
  logic                   out_free;
  logic                   hit;
  logic                   stall;
  logic                   adv;
  logic                   push;
  logic                   issue;
  logic [CNT_W-1:0]       n_nxt;
  logic                   idx_end;

  // saturating deadline
  assign now_w = TICK_BITS'(in_now_tick);
  assign sum_w = SUM_W'(now_w) + SUM_W'(in_delay_ticks);
  assign dl_w  = (sum_w > SUM_W'({TICK_BITS{1'b1}})) ? {TICK_BITS{1'b1}}
                                                       : TICK_BITS'(sum_w);

  assign rd_deadline = rdata[HANDLE_BITS +: TICK_BITS];
  assign rd_hnd      = rdata[HANDLE_BITS-1:0];

  assign out_free = !out_valid_r || out_ready;
  assign idx_end  = (idx_r == IDX_W'(SLOTS - 1));

  // scan: one read per cycle unless stalled, compared the cycle after
  assign hit   = cmd.scan && rd_v_r && active_r[rd_idx_r] && (rd_deadline < now_r);
  assign stall = hit && pend_v_r && !out_free;
  assign adv   = cmd.scan && !stall;
  assign push  = adv && hit && pend_v_r;
  assign n_nxt = hit ? (n_r + CNT_W'(1)) : n_r;
  assign issue = adv && !issue_done_r && (n_nxt < CNT_W'(MAX_RESULTS));

  otp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.create_take),
    .waddr (idx_r),
    .wdata ({dl_r, hnd_r}),
    .re    (issue),
    .raddr (idx_r),
    .rdata (rdata)
  );

  // item and scan payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      now_r <= now_w;
      dl_r  <= dl_w;
      hnd_r <= HANDLE_BITS'(in_handle);
    end
    if (issue) begin
      rd_idx_r <= idx_r;
    end
    if (adv && hit) begin
      pend_slot_r <= SLOT_W'(rd_idx_r);
      pend_hnd_r  <= rd_hnd;
    end
  end

  // scan control and active bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      issue_done_r <= 1'b0;
      rd_v_r       <= 1'b0;
      n_r          <= '0;
      active_r     <= '0;
      pend_v_r     <= 1'b0;
    end else begin
      if (cmd.capture) begin
        idx_r        <= '0;
        issue_done_r <= 1'b0;
        rd_v_r       <= 1'b0;
        n_r          <= '0;
        pend_v_r     <= 1'b0;
      end else if (cmd.next_slot) begin
        idx_r <= idx_r + IDX_W'(1);
      end else if (cmd.create_take) begin
        active_r[idx_r] <= 1'b1;
      end else if (adv) begin
        rd_v_r <= issue;
        n_r    <= n_nxt;
        if (issue) begin
          idx_r <= idx_r + IDX_W'(1);
          if (idx_end) begin
            issue_done_r <= 1'b1;
          end
        end
        if (hit) begin
          active_r[rd_idx_r] <= 1'b0;
          pend_v_r           <= 1'b1;
        end
      end else if (cmd.emit_final) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.create_take || cmd.emit_full || push || cmd.emit_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    priority if (cmd.create_take) begin
      out_status_r <= ST_CREATED;
      out_slot_r   <= SLOT_W'(idx_r);
      out_hnd_r    <= HANDLE_W'(hnd_r);
      out_last_r   <= 1'b1;
    end else if (cmd.emit_full) begin
      out_status_r <= ST_FULL;
      out_slot_r   <= '0;
      out_hnd_r    <= '0;
      out_last_r   <= 1'b1;
    end else if (push) begin
      out_status_r <= ST_EXPIRED;
      out_slot_r   <= pend_slot_r;
      out_hnd_r    <= HANDLE_W'(pend_hnd_r);
      out_last_r   <= 1'b0;
    end else if (cmd.emit_final) begin
      out_status_r <= pend_v_r ? ST_EXPIRED : ST_NONE;
      out_slot_r   <= pend_v_r ? pend_slot_r : '0;
      out_hnd_r    <= pend_v_r ? HANDLE_W'(pend_hnd_r) : '0;
      out_last_r   <= 1'b1;
    end else begin
      out_status_r <= out_status_r;
    end
  end

  assign sts.out_free  = out_free;
  assign sts.slot_free = !active_r[idx_r];
  assign sts.idx_end   = idx_end;
  assign sts.scan_done = !rd_v_r && (issue_done_r || (n_r == CNT_W'(MAX_RESULTS)));

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot           = out_slot_r;
  assign out_expired_handle = out_hnd_r;
  assign out_last           = out_last_r;

endmodule

// File: src/one_shot_timer_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_shot_timer_pool
// Fixed pool of one-shot timers: create claims the lowest free slot,
// check frees and reports up to MAX_RESULTS timers whose deadline has passed.
// ----------------------------------------------------------------------------
// Timing: create looks at one slot per cycle while the output register is
//   free; check steps the deadline RAM read port once per slot, and both
//   wait on output backpressure.
// Throughput: one item at a time; the next beat is taken once the current
//   item's last result sits in the output register.
// Reset: synchronous, active low; clears all active bits (every slot free).
//   Deadline/handle RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module one_shot_timer_pool
  import otp_pkg::*;
#(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned TICK_BITS   = 48,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // item channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [NOW_W-1:0]    in_now_tick,
  input  logic [DELAY_W-1:0]  in_delay_ticks,
  input  logic [HANDLE_W-1:0] in_handle,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [HANDLE_W-1:0] out_expired_handle,
  output logic                out_last
);

  otp_cmd_t cmd;
  otp_sts_t sts;

  // Sequencer: picks create search or check scan and closes each item.
  otp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: the held expiry delays each report by one hit so the final
  // one can carry last; the check stops after MAX_RESULTS expiries, and
  // remaining expired slots stay active for a later check.
  otp_datapath #(
    .SLOTS       (SLOTS),
    .TICK_BITS   (TICK_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_now_tick        (in_now_tick),
    .in_delay_ticks     (in_delay_ticks),
    .in_handle          (in_handle),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_slot           (out_slot),
    .out_expired_handle (out_expired_handle),
    .out_last           (out_last)
  );

endmodule
